[rtl/packet_deframer_with_checksum_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shared forms for concurrent checks on clk_i.
// ---------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_WITH_CHECKSUM_MACROS_SVH
`define PACKET_DEFRAMER_WITH_CHECKSUM_MACROS_SVH

// Check that is masked while reset is asserted
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that holds at every edge, reset included
`define PDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/pdc_pkg.sv]
// ---------------------------------------------------------------------------
// pdc_pkg
// Types and constants of the packet deframer with checksum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdc_pkg;

  // Frame layout
  localparam int unsigned HeaderBytes = 13;
  localparam int unsigned PosWidth    = 17;
  localparam logic [15:0] PayloadSizeReset = 16'd1024;

  // Header field boundaries (positions within the frame)
  localparam logic [PosWidth-1:0] PosKind     = 17'd0;
  localparam logic [PosWidth-1:0] PosSeqLast  = 17'd8;
  localparam logic [PosWidth-1:0] PosCntLast  = 17'd12;
  localparam logic [PosWidth-1:0] PosHdrBytes = 17'd13;

  typedef enum logic {
    REC_PAYLOAD = 1'b0,
    REC_VERDICT = 1'b1
  } rec_e;

  typedef enum logic [1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_CKSUM_BAD = 2'd1,
    STATUS_COUNT_BAD = 2'd2
  } status_e;

  // One result record
  typedef struct packed {
    rec_e               record_type;
    logic [7:0]         payload_byte;
    logic [15:0]        byte_index;
    logic [7:0]         frame_kind;
    logic signed [63:0] sequence_res;
    logic [15:0]        valid_count;
    status_e            status;
  } result_t;

endpackage

[rtl/pdc_parser.sv]
// ---------------------------------------------------------------------------
// pdc_parser
// Frame position, running sum and header capture; builds one record per
// beat when the byte is an emitted payload byte or the checksum byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_deframer_with_checksum_macros.svh"

module pdc_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       byte_i,
  input  logic [15:0]      payload_size_i,
  output logic             res_valid_o,
  output pdc_pkg::result_t res_o
);
  import pdc_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          kind_q, kind_d;
  logic [63:0]         seq_q, seq_d;
  logic [31:0]         cnt_q, cnt_d;

  logic [PosWidth-1:0] frame_end;
  logic [PosWidth-1:0] pay_idx;
  logic                at_check;
  logic                count_good;
  logic [7:0]          expect_sum;

  assign frame_end  = PosHdrBytes + {1'b0, payload_size_i};
  assign at_check   = (pos_q >= frame_end);
  assign count_good = (cnt_q <= {16'd0, payload_size_i});
  assign expect_sum = 8'd0 - sum_q;
  assign pay_idx    = pos_q - PosHdrBytes;

  // Next state and record for the current beat
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    kind_d      = kind_q;
    seq_d       = seq_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (beat_i) begin
      if (at_check) begin
        // checksum byte: verdict, then start a fresh frame
        res_valid_o        = 1'b1;
        res_o.record_type  = REC_VERDICT;
        res_o.frame_kind   = kind_q;
        res_o.sequence_res = seq_q;
        res_o.valid_count  = count_good ? cnt_q[15:0] : 16'd0;
        if (byte_i != expect_sum) begin
          res_o.status = STATUS_CKSUM_BAD;
        end else if (!count_good) begin
          res_o.status = STATUS_COUNT_BAD;
        end else begin
          res_o.status = STATUS_GOOD;
        end
        pos_d  = '0;
        sum_d  = '0;
        kind_d = '0;
        seq_d  = '0;
        cnt_d  = '0;
      end else begin
        sum_d = sum_q + byte_i;
        pos_d = pos_q + PosWidth'(1);
        if (pos_q == PosKind) begin
          kind_d = byte_i;
        end else if (pos_q <= PosSeqLast) begin
          seq_d = {seq_q[55:0], byte_i};
        end else if (pos_q <= PosCntLast) begin
          cnt_d = {cnt_q[23:0], byte_i};
        end else if (count_good && ({15'd0, pay_idx} < cnt_q)) begin
          // payload byte below the count; padding is only summed
          res_valid_o        = 1'b1;
          res_o.record_type  = REC_PAYLOAD;
          res_o.payload_byte = byte_i;
          res_o.byte_index   = pay_idx[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      kind_q <= '0;
      seq_q  <= '0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      kind_q <= kind_d;
      seq_q  <= seq_d;
      cnt_q  <= cnt_d;
    end
  end

  // A checksum beat always restarts the frame
  `PDC_ASSERT(a_check_restarts, beat_i && at_check |=> pos_q == '0 && sum_q == '0, "no frame restart")
  // Header bytes never produce a record
  `PDC_ASSERT(a_hdr_silent, beat_i && pos_q < PosHdrBytes |-> !res_valid_o, "record on header byte")

endmodule

[rtl/pdc_out_buf.sv]
// ---------------------------------------------------------------------------
// pdc_out_buf
// Output register with a skid stage; takes a record every cycle unless
// both entries are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_deframer_with_checksum_macros.svh"

module pdc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pdc_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pdc_pkg::result_t out_data_o
);
  import pdc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop = out_valid_q && !out_stall_i;

  // Fill and drain of the two entries
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // upstream is stalled here, so no push arrives
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The skid entry is only ever filled behind a held output
  `PDC_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry valid with empty output register")
  // A taken beat drains the skid entry
  `PDC_ASSERT(a_skid_drains, skid_valid_q && !out_stall_i |=> !skid_valid_q, "skid entry not drained after output beat")
  // No push may land while both entries are full
  `PDC_ASSERT(a_no_push_full, skid_valid_q |-> !push_i, "record pushed into a full buffer")

endmodule

[rtl/packet_deframer_with_checksum.sv]
// ---------------------------------------------------------------------------
// packet_deframer_with_checksum
// Fixed-length frame deframer: emits valid payload bytes as they arrive and
// a verdict record (good, checksum mismatch, bad count) on the checksum byte.
//
//   channel | direction | handshake                | beat contents
//   --------+-----------+--------------------------+---------------------------
//   in      | in        | in_valid_i / in_stall_o  | in_byte_i
//   out     | out       | out_valid_o / out_stall_i| record_type_o .. status_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_data_i (payload_size)
//
// One input beat per cycle while in_stall_o is low; each record is registered
// into the output buffer. The frame counter, running sum and header registers
// are updated in the cycle of the beat, feeding a two-entry output buffer.
// Reset clears the frame state and loads payload_size with 1024.
// in_stall_o rises only while both output entries hold records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_deframer_with_checksum (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input bytes
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  // result records
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               record_type_o,
  output logic [7:0]         payload_byte_o,
  output logic [15:0]        byte_index_o,
  output logic [7:0]         frame_kind_o,
  output logic signed [63:0] sequence_res_o,
  output logic [15:0]        valid_count_o,
  output logic [1:0]         status_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import pdc_pkg::*;

  logic        beat;
  logic        res_valid;
  logic        buf_full;
  result_t     res;
  result_t     out_rec;
  logic [15:0] payload_size_q;

  assign beat        = in_valid_i && !buf_full;
  assign in_stall_o  = buf_full;
  assign cfg_ready_o = 1'b1;

  // payload_size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_size_q <= PayloadSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      payload_size_q <= cfg_data_i;
    end
  end

  pdc_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .byte_i         (in_byte_i),
    .payload_size_i (payload_size_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  pdc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_rec)
  );

  assign record_type_o  = out_rec.record_type;
  assign payload_byte_o = out_rec.payload_byte;
  assign byte_index_o   = out_rec.byte_index;
  assign frame_kind_o   = out_rec.frame_kind;
  assign sequence_res_o = out_rec.sequence_res;
  assign valid_count_o  = out_rec.valid_count;
  assign status_o       = out_rec.status;

endmodule
